// ===== sv/stc_pkg.sv =====
// Shared types, constants and helper functions for the source token classifier.
package stc_pkg;

    localparam int KEYWORD_WINDOW = 7;
    localparam int KW_IDX_W       = $clog2(KEYWORD_WINDOW);
    localparam int LENGTH_LIMIT   = 255;
    localparam int LEN_CAP        = (LENGTH_LIMIT > 255) ? 255 : LENGTH_LIMIT;
    localparam int MAX_TOKS       = 3;
    localparam int QDEPTH         = 4;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam int NUM_KW         = 10;

    // Token kinds
    localparam logic [4:0] K_DTYPE    = 5'd0;
    localparam logic [4:0] K_DECISION = 5'd1;
    localparam logic [4:0] K_LOOP     = 5'd2;
    localparam logic [4:0] K_READ     = 5'd3;
    localparam logic [4:0] K_WRITE    = 5'd4;
    localparam logic [4:0] K_FUNC     = 5'd5;
    localparam logic [4:0] K_ARITH    = 5'd6;
    localparam logic [4:0] K_REL      = 5'd7;
    localparam logic [4:0] K_INPUT    = 5'd8;
    localparam logic [4:0] K_IDENT    = 5'd9;
    localparam logic [4:0] K_ASSIGN   = 5'd10;
    localparam logic [4:0] K_RETURN   = 5'd11;
    localparam logic [4:0] K_CONST    = 5'd12;
    localparam logic [4:0] K_STRING   = 5'd13;
    localparam logic [4:0] K_NUMBER   = 5'd14;
    localparam logic [4:0] K_BRACKET  = 5'd15;
    localparam logic [4:0] K_PUNCT    = 5'd16;
    localparam logic [4:0] K_COMMENT  = 5'd17;
    localparam logic [4:0] K_INVALID  = 5'd18;

    // Relational operator details
    localparam logic [7:0] REL_EQ = 8'd0;
    localparam logic [7:0] REL_LT = 8'd1;
    localparam logic [7:0] REL_LE = 8'd2;
    localparam logic [7:0] REL_GT = 8'd3;
    localparam logic [7:0] REL_GE = 8'd4;
    localparam logic [7:0] REL_NE = 8'd5;

    // Invalid token causes
    localparam logic [7:0] INV_CHAR    = 8'd1;
    localparam logic [7:0] INV_LITERAL = 8'd2;
    localparam logic [7:0] INV_STRING  = 8'd3;
    localparam logic [7:0] INV_COMMENT = 8'd4;

    // Keyword table
    localparam logic [55:0] KW_TEXT [NUM_KW] = '{
        "Integer", "char", "if", "else", "elif",
        "print", "println", "func", "In", "while"
    };
    localparam logic [7:0] KW_LEN [NUM_KW] = '{
        8'd7, 8'd4, 8'd2, 8'd4, 8'd4, 8'd5, 8'd7, 8'd4, 8'd2, 8'd5
    };
    localparam logic [4:0] KW_KIND [NUM_KW] = '{
        K_DTYPE, K_DTYPE, K_DECISION, K_DECISION, K_DECISION,
        K_WRITE, K_WRITE, K_FUNC, K_READ, K_LOOP
    };

    typedef logic [KEYWORD_WINDOW-1:0][7:0] win_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } char_word_t;

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] detail;
        logic [7:0] length;
        logic       clipped;
    } tok_t;

    typedef struct packed {
        logic [4:0] token_kind;
        logic [7:0] detail;
        logic [7:0] token_length;
        logic       length_clipped;
        logic       last_of_run;
    } tok_word_t;

    // Tokens raised by one character
    typedef struct packed {
        logic [1:0]           count;
        tok_t [MAX_TOKS-1:0]  toks;
    } grp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic tok_t mk_tok(logic [4:0] kind, logic [7:0] detail,
                                    logic [7:0] length, logic clipped);
        tok_t t;
        t.kind    = kind;
        t.detail  = detail;
        t.length  = length;
        t.clipped = clipped;
        return t;
    endfunction

    // Append a token, dropping any beyond the third
    function automatic grp_t push_tok(grp_t g, tok_t t);
        grp_t r;
        r = g;
        if (g.count != 2'd3)
        begin
            r.toks[g.count] = t;
            r.count         = g.count + 2'd1;
        end
        return r;
    endfunction

    // Close an identifier, promoting it to a keyword on a full match
    function automatic tok_t ident_tok(win_t win, logic [7:0] len, logic clip);
        tok_t t;
        logic hit;
        logic ok;
        t   = mk_tok(K_IDENT, 8'd0, len, clip);
        hit = 1'b0;
        if (!clip && len <= 8'(KEYWORD_WINDOW))
        begin
            for (int i = 0; i < NUM_KW; i++)
            begin
                ok = (len == KW_LEN[i]);
                for (int j = 0; j < 7; j++)
                begin
                    if (j < int'(KW_LEN[i]))
                        ok = ok && (win[j] == KW_TEXT[i][8*(int'(KW_LEN[i])-1-j) +: 8]);
                end
                if (ok && !hit)
                begin
                    hit      = 1'b1;
                    t.kind   = KW_KIND[i];
                    t.detail = 8'(i);
                end
            end
        end
        return t;
    endfunction

endpackage

// ===== sv/stc_front.sv =====
// Front end: per-character lexer state and token classification.
module stc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  stc_pkg::char_word_t char_word,
    output stc_pkg::grp_t       grp
);

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUM, M_MINUS, M_GT, M_LT, M_COLON, M_SLASH,
        M_COMMENT, M_QUOTE, M_QUOTE_CH, M_STRING
    } mode_t;

    mode_t         mode_reg, mode_next;
    logic [7:0]    len_reg, len_next;
    logic          clip_reg, clip_next;
    logic [7:0]    held_reg, held_next;
    logic          star_reg, star_next;
    stc_pkg::win_t win_reg, win_next;

    logic [7:0]    c;
    logic          restart;

    // Run one character through the lexer
    always_comb
    begin
        c         = char_word.char_code;
        mode_next = mode_reg;
        len_next  = len_reg;
        clip_next = clip_reg;
        held_next = held_reg;
        star_next = star_reg;
        win_next  = win_reg;
        restart   = 1'b0;
        grp       = '0;

        unique case (mode_reg)
            M_IDENT:
            begin
                if (stc_pkg::is_alpha(c) || stc_pkg::is_digit(c))
                begin
                    if (!clip_next && len_next < 8'(stc_pkg::KEYWORD_WINDOW))
                        win_next[len_next[stc_pkg::KW_IDX_W-1:0]] = c;
                    if (len_next < 8'(stc_pkg::LEN_CAP)) len_next = len_next + 8'd1;
                    else clip_next = 1'b1;
                end
                else
                begin
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::ident_tok(win_next, len_next, clip_next));
                    restart = 1'b1;
                end
            end
            M_NUM:
            begin
                if (stc_pkg::is_digit(c))
                begin
                    if (len_next < 8'(stc_pkg::LEN_CAP)) len_next = len_next + 8'd1;
                    else clip_next = 1'b1;
                end
                else
                begin
                    grp = stc_pkg::push_tok(grp, stc_pkg::mk_tok(stc_pkg::K_NUMBER,
                        {7'd0, held_next == 8'h2d}, len_next, clip_next));
                    restart = 1'b1;
                end
            end
            M_MINUS:
            begin
                if (stc_pkg::is_digit(c))
                begin
                    mode_next = M_NUM;
                    len_next  = 8'd2;
                    clip_next = 1'b0;
                    held_next = 8'h2d;
                end
                else
                begin
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_ARITH, 8'h2d, 8'd1, 1'b0));
                    restart = 1'b1;
                end
            end
            M_GT:
            begin
                mode_next = M_IDLE;
                if (c == 8'h3d)
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_REL, stc_pkg::REL_GE, 8'd2, 1'b0));
                else if (c == 8'h3e)
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_INPUT, 8'd0, 8'd2, 1'b0));
                else
                begin
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_REL, stc_pkg::REL_GT, 8'd1, 1'b0));
                    restart = 1'b1;
                end
            end
            M_LT:
            begin
                mode_next = M_IDLE;
                if (c == 8'h3d)
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_REL, stc_pkg::REL_LE, 8'd2, 1'b0));
                else
                begin
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_REL, stc_pkg::REL_LT, 8'd1, 1'b0));
                    restart = 1'b1;
                end
            end
            M_COLON:
            begin
                mode_next = M_IDLE;
                if (c == 8'h3d)
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_ASSIGN, 8'd0, 8'd2, 1'b0));
                else
                begin
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_PUNCT, 8'h3a, 8'd1, 1'b0));
                    restart = 1'b1;
                end
            end
            M_SLASH:
            begin
                mode_next = M_IDLE;
                if (c == 8'h3d)
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_REL, stc_pkg::REL_NE, 8'd2, 1'b0));
                else if (c == 8'h2a)
                begin
                    mode_next = M_COMMENT;
                    len_next  = 8'd2;
                    clip_next = 1'b0;
                    star_next = 1'b0;
                end
                else
                begin
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_ARITH, 8'h2f, 8'd1, 1'b0));
                    restart = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (len_next < 8'(stc_pkg::LEN_CAP)) len_next = len_next + 8'd1;
                else clip_next = 1'b1;
                if (star_next && c == 8'h2f)
                begin
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_COMMENT, 8'd0, len_next, clip_next));
                    mode_next = M_IDLE;
                    star_next = 1'b0;
                end
                else
                    star_next = (c == 8'h2a);
            end
            M_QUOTE:
            begin
                if (stc_pkg::is_alpha(c))
                begin
                    held_next = c;
                    mode_next = M_QUOTE_CH;
                end
                else
                begin
                    grp = stc_pkg::push_tok(grp, stc_pkg::mk_tok(stc_pkg::K_INVALID,
                        stc_pkg::INV_LITERAL, 8'd1, 1'b0));
                    restart = 1'b1;
                end
            end
            M_QUOTE_CH:
            begin
                if (c == 8'h27)
                begin
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_CONST, held_next, 8'd3, 1'b0));
                    mode_next = M_IDLE;
                end
                else
                begin
                    // Bad literal: the held letter opens an identifier
                    grp = stc_pkg::push_tok(grp, stc_pkg::mk_tok(stc_pkg::K_INVALID,
                        stc_pkg::INV_LITERAL, 8'd1, 1'b0));
                    win_next[0] = held_next;
                    clip_next   = 1'b0;
                    if (stc_pkg::is_alpha(c) || stc_pkg::is_digit(c))
                    begin
                        mode_next   = M_IDENT;
                        win_next[1] = c;
                        len_next    = 8'd2;
                    end
                    else
                    begin
                        grp = stc_pkg::push_tok(grp,
                            stc_pkg::mk_tok(stc_pkg::K_IDENT, 8'd0, 8'd1, 1'b0));
                        restart = 1'b1;
                    end
                end
            end
            M_STRING:
            begin
                if (len_next < 8'(stc_pkg::LEN_CAP)) len_next = len_next + 8'd1;
                else clip_next = 1'b1;
                if (c == 8'h22)
                begin
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_STRING, 8'd0, len_next, clip_next));
                    mode_next = M_IDLE;
                end
            end
            default:
                restart = 1'b1;
        endcase

        // Start a fresh token on this character
        if (restart)
        begin
            mode_next = M_IDLE;
            if (c == 8'h20 || c == 8'h09 || c == 8'h0a)
                mode_next = M_IDLE;
            else if (stc_pkg::is_alpha(c))
            begin
                mode_next   = M_IDENT;
                len_next    = 8'd1;
                clip_next   = 1'b0;
                win_next[0] = c;
            end
            else if (stc_pkg::is_digit(c))
            begin
                mode_next = M_NUM;
                len_next  = 8'd1;
                clip_next = 1'b0;
                held_next = 8'd0;
            end
            else
            begin
                unique case (c)
                    8'h28, 8'h29, 8'h5b, 8'h5d, 8'h7b, 8'h7d:
                        grp = stc_pkg::push_tok(grp,
                            stc_pkg::mk_tok(stc_pkg::K_BRACKET, c, 8'd1, 1'b0));
                    8'h3b, 8'h2c:
                        grp = stc_pkg::push_tok(grp,
                            stc_pkg::mk_tok(stc_pkg::K_PUNCT, c, 8'd1, 1'b0));
                    8'h2b, 8'h2a:
                        grp = stc_pkg::push_tok(grp,
                            stc_pkg::mk_tok(stc_pkg::K_ARITH, c, 8'd1, 1'b0));
                    8'h3d:
                        grp = stc_pkg::push_tok(grp,
                            stc_pkg::mk_tok(stc_pkg::K_REL, stc_pkg::REL_EQ, 8'd1, 1'b0));
                    8'h3e: mode_next = M_GT;
                    8'h3c: mode_next = M_LT;
                    8'h3a: mode_next = M_COLON;
                    8'h2d: mode_next = M_MINUS;
                    8'h2f: mode_next = M_SLASH;
                    8'h27: mode_next = M_QUOTE;
                    8'h22:
                    begin
                        mode_next = M_STRING;
                        len_next  = 8'd1;
                        clip_next = 1'b0;
                    end
                    default:
                        grp = stc_pkg::push_tok(grp, stc_pkg::mk_tok(stc_pkg::K_INVALID,
                            stc_pkg::INV_CHAR, 8'd1, 1'b0));
                endcase
            end
        end

        // Flush the pending token on the last character
        if (char_word.end_of_input)
        begin
            unique case (mode_next)
                M_IDENT:
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::ident_tok(win_next, len_next, clip_next));
                M_NUM:
                    grp = stc_pkg::push_tok(grp, stc_pkg::mk_tok(stc_pkg::K_NUMBER,
                        {7'd0, held_next == 8'h2d}, len_next, clip_next));
                M_MINUS:
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_ARITH, 8'h2d, 8'd1, 1'b0));
                M_GT:
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_REL, stc_pkg::REL_GT, 8'd1, 1'b0));
                M_LT:
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_REL, stc_pkg::REL_LT, 8'd1, 1'b0));
                M_COLON:
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_PUNCT, 8'h3a, 8'd1, 1'b0));
                M_SLASH:
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_ARITH, 8'h2f, 8'd1, 1'b0));
                M_COMMENT:
                    grp = stc_pkg::push_tok(grp, stc_pkg::mk_tok(stc_pkg::K_INVALID,
                        stc_pkg::INV_COMMENT, len_next, clip_next));
                M_QUOTE:
                    grp = stc_pkg::push_tok(grp, stc_pkg::mk_tok(stc_pkg::K_INVALID,
                        stc_pkg::INV_LITERAL, 8'd1, 1'b0));
                M_QUOTE_CH:
                begin
                    grp = stc_pkg::push_tok(grp, stc_pkg::mk_tok(stc_pkg::K_INVALID,
                        stc_pkg::INV_LITERAL, 8'd1, 1'b0));
                    grp = stc_pkg::push_tok(grp,
                        stc_pkg::mk_tok(stc_pkg::K_IDENT, 8'd0, 8'd1, 1'b0));
                end
                M_STRING:
                    grp = stc_pkg::push_tok(grp, stc_pkg::mk_tok(stc_pkg::K_INVALID,
                        stc_pkg::INV_STRING, len_next, clip_next));
                default: ;
            endcase
            mode_next = M_IDLE;
            star_next = 1'b0;
        end
    end

    // Hold lexer state, advance on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            len_reg  <= 8'd0;
            clip_reg <= 1'b0;
            held_reg <= 8'd0;
            star_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            clip_reg <= clip_next;
            held_reg <= held_next;
            star_reg <= star_next;
        end
    end

    // Keyword window has no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            win_reg <= win_next;
    end

endmodule

// ===== sv/stc_queue.sv =====
// Short queue of token groups between the front and back ends.
module stc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  stc_pkg::grp_t       push_grp,
    input  logic                pop,
    output stc_pkg::grp_t       pop_grp,
    output stc_pkg::q_status_t  status
);

    stc_pkg::grp_t                mem [stc_pkg::QDEPTH];
    logic [stc_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [stc_pkg::QPTR_W:0]     count_reg;

    assign status.full  = (count_reg == (stc_pkg::QPTR_W+1)'(stc_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_grp      = mem[rd_ptr_reg];

    // Write storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_grp;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== sv/stc_back.sv =====
// Back end: unpacks token groups and presents one token word at a time.
module stc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  stc_pkg::q_status_t  q_status,
    input  stc_pkg::grp_t       q_grp,
    output logic                q_pop,
    output logic                tok_valid,
    input  logic                tok_stall,
    output stc_pkg::tok_word_t  tok_word
);

    stc_pkg::grp_t cur_reg;
    logic [1:0]    idx_reg;
    logic          valid_reg;
    logic          last;
    logic          taken;
    stc_pkg::tok_t t;

    assign last      = (idx_reg == cur_reg.count - 2'd1);
    assign taken     = valid_reg && !tok_stall;
    assign q_pop     = !q_status.empty && (!valid_reg || (taken && last));
    assign tok_valid = valid_reg;

    // Select the current token
    always_comb
    begin
        t                       = cur_reg.toks[idx_reg];
        tok_word.token_kind     = t.kind;
        tok_word.detail         = t.detail;
        tok_word.token_length   = t.length;
        tok_word.length_clipped = t.clipped;
        tok_word.last_of_run    = last;
    end

    // Load a group, step through its tokens
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end
        else if (taken)
        begin
            if (last) valid_reg <= 1'b0;
            else      idx_reg   <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_grp;
    end

endmodule

// ===== sv/source_token_classifier.sv =====
// Top level: one source character per word in, classified token words out.
// With the queue empty and the output free, a character's token group is written into the queue
// at the edge that takes the character and then loaded into the back end's output register.
// Throughput: one character per cycle while each raises at most one token and tok_stall is low; a
// character raising k tokens holds the output for k token words, the group queue absorbing it.
// The input stalls while the four-group queue is full.
// Reset: asynchronous, active low; lexer idle, queue empty, no word on the output.
module source_token_classifier (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_stall,
    input  stc_pkg::char_word_t char_word,
    output logic                tok_valid,
    input  logic                tok_stall,
    output stc_pkg::tok_word_t  tok_word
);

    logic               accept;
    logic               q_pop;
    stc_pkg::grp_t      grp;
    stc_pkg::grp_t      q_grp;
    stc_pkg::q_status_t q_status;

    assign char_stall = q_status.full;
    assign accept     = char_valid && !q_status.full;

    stc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_word (char_word),
        .grp       (grp)
    );

    stc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept && grp.count != 2'd0),
        .push_grp (grp),
        .pop      (q_pop),
        .pop_grp  (q_grp),
        .status   (q_status)
    );

    stc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_grp     (q_grp),
        .q_pop     (q_pop),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_word  (tok_word)
    );

endmodule

// ===== sv/stc_checker.sv =====
// Port-level checks on the token classifier, bound to the top level.
module stc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                tok_valid,
    input logic                tok_stall,
    input stc_pkg::tok_word_t  tok_word
);

    // Hold a stalled word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_stall |=> tok_valid && $stable(tok_word))
        else $error("stalled token word changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> tok_word.token_kind <= stc_pkg::K_INVALID)
        else $error("token kind out of range");

    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_word.length_clipped |->
            tok_word.token_length == 8'(stc_pkg::LEN_CAP))
        else $error("clipped token below length cap");

    a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_word.token_kind == stc_pkg::K_BRACKET |->
            tok_word.token_length == 8'd1 && !tok_word.length_clipped)
        else $error("bracket token with wrong length");

endmodule

bind source_token_classifier stc_checker u_stc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_word  (tok_word)
);
